### design/rrst_pkg.sv
// ----------------------------------------------------------------------------
// rrst_pkg
// Types, codes and helpers shared by the resident slot table modules.
// ----------------------------------------------------------------------------
package rrst_pkg;

  localparam int unsigned MAX_EXPERTS = 256;
  localparam int unsigned APB_AW      = 4;

  // Register byte addresses, divided by four.
  localparam logic [1:0] REG_EXPERT_COUNT = 2'd0;
  localparam logic [1:0] REG_NUM_SLOTS    = 2'd1;
  localparam logic [1:0] REG_SLOT_SIZE    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_BEGIN_USE = 2'd1,
    CMD_END_USE   = 2'd2,
    CMD_EVICT     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SS_FREE     = 2'd0,
    SS_LOADING  = 2'd1,
    SS_RESIDENT = 2'd2,
    SS_IN_USE   = 2'd3
  } slot_state_e;

  typedef enum logic [3:0] {
    ST_OK               = 4'd0,
    ST_EXPERT_RANGE     = 4'd1,
    ST_SIZE             = 4'd2,
    ST_MAP_RANGE        = 4'd3,
    ST_MAP_MISMATCH     = 4'd4,
    ST_IN_USE           = 4'd5,
    ST_NOT_READY_RELOAD = 4'd6,
    ST_NO_FREE_SLOT     = 4'd7,
    ST_NOT_RESIDENT     = 4'd8,
    ST_NOT_READY_USE    = 4'd9,
    ST_NO_REFERENCE     = 4'd10,
    ST_CANNOT_EVICT     = 4'd11,
    ST_COUNT_FULL       = 4'd12
  } status_e;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] expert;
    logic       expert_ok;
    logic       load_ok;
  } rrst_req_t;

  typedef struct packed {
    logic        ok;
    status_e     status;
    logic [4:0]  slot;
    slot_state_e slot_state;
    logic [15:0] ref_count;
    logic [31:0] generation;
  } rrst_result_t;

  function automatic logic [31:0] bump_gen(input logic [31:0] g);
    bump_gen = (g == 32'hFFFF_FFFF) ? 32'd1 : g + 32'd1;
  endfunction

endpackage

### design/rrst_front.sv
// ----------------------------------------------------------------------------
// rrst_front
// Accepts requests and classifies them against the configuration.
// ----------------------------------------------------------------------------
module rrst_front import rrst_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  expert_i,
  input  logic [31:0] load_bytes_i,
  input  logic        payload_present_i,
  input  logic [8:0]  eff_experts_i,
  input  logic [31:0] slot_size_i,
  output logic        push_o,
  input  logic        push_ready_i,
  output rrst_req_t   req_o
);

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i;

  always_comb begin
    req_o.cmd       = cmd_e'(command_i);
    req_o.expert    = expert_i;
    req_o.expert_ok = {1'b0, expert_i} < eff_experts_i;
    req_o.load_ok   = payload_present_i && (load_bytes_i == slot_size_i);
  end

endmodule

### design/rrst_fifo.sv
// ----------------------------------------------------------------------------
// rrst_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module rrst_fifo import rrst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      push_ready_o,
  input  rrst_req_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_i,
  output rrst_req_t pop_data_o
);

  rrst_req_t   mem_q [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rp_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

### design/rrst_back.sv
// ----------------------------------------------------------------------------
// rrst_back
// Slot table: searches the slots for a request, then updates them and
// registers the result.
// ----------------------------------------------------------------------------
module rrst_back import rrst_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  rrst_req_t    req_i,
  output logic         req_pop_o,
  input  logic [8:0]   eff_slots_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output rrst_result_t result_o
);

  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  localparam logic PH_SEARCH = 1'b0;
  localparam logic PH_EXEC   = 1'b1;

  logic ph_q, ph_d;

  slot_state_e st_q    [MAX_SLOTS];
  logic [7:0]  owner_q [MAX_SLOTS];
  logic [15:0] refs_q  [MAX_SLOTS];
  logic [31:0] gen_q   [MAX_SLOTS];

  // Search results
  logic          hit_any, free_any;
  logic [SW-1:0] hit_idx, free_idx;

  // Request held for the update cycle
  rrst_req_t     req_q;
  logic          mapped_q, have_q, free_any_q;
  logic [SW-1:0] s_q, free_idx_q;

  // Update cycle
  logic          exec_go, do_write, set_owner, have;
  logic [SW-1:0] tgt;
  status_e       status;
  slot_state_e   cur_st, new_st;
  logic [15:0]   cur_refs, new_refs;
  logic [31:0]   cur_gen, new_gen;

  logic          out_valid_q;
  rrst_result_t  result_q;

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (!hit_any && st_q[i] != SS_FREE && owner_q[i] == req_i.expert) begin
        hit_any = 1'b1;
        hit_idx = SW'(i);
      end
      if (!free_any && 9'(i) < eff_slots_i && st_q[i] == SS_FREE) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign req_pop_o = (ph_q == PH_SEARCH) && req_valid_i;
  assign exec_go   = (ph_q == PH_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      PH_SEARCH: if (req_valid_i) ph_d = PH_EXEC;
      PH_EXEC:   if (exec_go) ph_d = PH_SEARCH;
      default:   ph_d = PH_SEARCH;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      req_q      <= req_i;
      mapped_q   <= req_i.expert_ok && hit_any;
      have_q     <= req_i.expert_ok && hit_any && (9'(hit_idx) < eff_slots_i);
      s_q        <= hit_idx;
      free_any_q <= free_any;
      free_idx_q <= free_idx;
    end
  end

  always_comb begin
    // A load of an unmapped expert works on the lowest free slot.
    tgt = (req_q.cmd == CMD_LOAD && req_q.expert_ok && req_q.load_ok && !mapped_q)
        ? free_idx_q : s_q;
    cur_st    = st_q[tgt];
    cur_refs  = refs_q[tgt];
    cur_gen   = gen_q[tgt];
    new_st    = cur_st;
    new_refs  = cur_refs;
    new_gen   = cur_gen;
    have      = have_q;
    status    = ST_OK;
    set_owner = 1'b0;
    do_write  = 1'b0;
    if (req_q.cmd == CMD_LOAD) begin
      if (!req_q.expert_ok) begin
        status = ST_EXPERT_RANGE;
      end else if (!req_q.load_ok) begin
        status = ST_SIZE;
        have   = 1'b0;
      end else if (mapped_q) begin
        if (!have_q) status = ST_MAP_RANGE;
        else if (cur_refs != 16'd0 || cur_st == SS_IN_USE) status = ST_IN_USE;
        else if (cur_st != SS_RESIDENT) status = ST_NOT_READY_RELOAD;
      end else if (!free_any_q) begin
        status = ST_NO_FREE_SLOT;
      end else begin
        have      = 1'b1;
        set_owner = 1'b1;
        new_refs  = 16'd0;
      end
      if (status == ST_OK) begin
        new_st   = SS_RESIDENT;
        new_gen  = bump_gen(cur_gen);
        do_write = 1'b1;
      end
    end else if (!mapped_q) begin
      status = ST_NOT_RESIDENT;
    end else if (!have_q) begin
      status = ST_MAP_RANGE;
    end else begin
      case (req_q.cmd)
        CMD_BEGIN_USE: begin
          if (cur_st != SS_RESIDENT && cur_st != SS_IN_USE) begin
            status = ST_NOT_READY_USE;
          end else if (cur_refs == 16'hFFFF) begin
            status = ST_COUNT_FULL;
          end else begin
            new_st   = SS_IN_USE;
            new_refs = cur_refs + 16'd1;
            do_write = 1'b1;
          end
        end
        CMD_END_USE: begin
          if (cur_refs == 16'd0) begin
            status = ST_NO_REFERENCE;
          end else begin
            new_refs = cur_refs - 16'd1;
            if (new_refs == 16'd0) new_st = SS_RESIDENT;
            do_write = 1'b1;
          end
        end
        default: begin
          if (cur_st != SS_RESIDENT || cur_refs != 16'd0) begin
            status = ST_CANNOT_EVICT;
          end else begin
            new_st   = SS_FREE;
            new_refs = 16'd0;
            do_write = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_SEARCH;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        st_q[i]   <= SS_FREE;
        refs_q[i] <= 16'd0;
        gen_q[i]  <= 32'd0;
      end
    end else begin
      ph_q <= ph_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec_go && do_write) begin
        st_q[tgt]   <= new_st;
        refs_q[tgt] <= new_refs;
        gen_q[tgt]  <= new_gen;
      end
    end
  end

  // The owner only means something while the slot is not free.
  always_ff @(posedge clk_i) begin
    if (exec_go && set_owner) begin
      owner_q[tgt] <= req_q.expert;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      result_q.ok     <= (status == ST_OK);
      result_q.status <= status;
      if (have) begin
        result_q.slot       <= 5'(tgt);
        result_q.slot_state <= new_st;
        result_q.ref_count  <= new_refs;
        result_q.generation <= new_gen;
      end else begin
        result_q.slot       <= 5'd0;
        result_q.slot_state <= SS_FREE;
        result_q.ref_count  <= 16'd0;
        result_q.generation <= 32'd0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  a_ok_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.ok == (result_q.status == ST_OK)))
    else $error("ok flag disagrees with status");

  a_in_use_has_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.slot_state == SS_IN_USE |-> result_q.ref_count != 16'd0)
    else $error("slot in use without references");

  a_exec_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_EXEC) && !exec_go |=> (ph_q == PH_EXEC))
    else $error("request dropped while result stalled");

  a_no_pop_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_EXEC) |-> !req_pop_o)
    else $error("request popped during update");

endmodule

### design/refcounted_resident_slot_table.sv
// ----------------------------------------------------------------------------
// refcounted_resident_slot_table
// Reference-counted map from logical experts to physical slots.
// ----------------------------------------------------------------------------
// Each request (load, begin use, end use, evict) returns one result with a
// status code and the fields of the slot it resolved. Requests enter a
// two-entry queue; the table then searches all slots for the expert's owner
// and the lowest free slot, then updates the slot and registers the result.
// A new request is taken only once the last is through; the update waits
// while a held result is not taken. The expert map is kept as the owner
// field of each occupied slot, so no clearing is needed after reset. The
// use token is not stored, as nothing reads it back.
// Registers: 0x0 expert count, 0x4 number of slots, 0x8 slot size in bytes.
module refcounted_resident_slot_table import rrst_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        expert_i,
  input  logic [63:0]       use_token_i,
  input  logic [31:0]       load_bytes_i,
  input  logic              payload_present_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [3:0]        status_o,
  output logic [4:0]        slot_o,
  output logic [1:0]        slot_state_o,
  output logic [15:0]       ref_count_o,
  output logic [31:0]       generation_o
);

  logic [8:0]   expert_count_q;
  logic [5:0]   num_slots_q;
  logic [31:0]  slot_size_q;
  logic [8:0]   eff_experts, eff_slots;
  logic         cfg_wr;
  logic         push, push_ready, pop_valid, pop;
  rrst_req_t    push_req, pop_req;
  rrst_result_t result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expert_count_q <= 9'd256;
      num_slots_q    <= 6'd32;
      slot_size_q    <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_EXPERT_COUNT: expert_count_q <= pwdata[8:0];
        REG_NUM_SLOTS:    num_slots_q    <= pwdata[5:0];
        REG_SLOT_SIZE:    slot_size_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_EXPERT_COUNT: prdata = {23'd0, expert_count_q};
      REG_NUM_SLOTS:    prdata = {26'd0, num_slots_q};
      REG_SLOT_SIZE:    prdata = slot_size_q;
      default:          prdata = 32'd0;
    endcase
  end

  assign eff_experts = (32'(expert_count_q) > MAX_EXPERTS) ? 9'(MAX_EXPERTS)
                     : expert_count_q;
  assign eff_slots   = (32'(num_slots_q) > MAX_SLOTS) ? 9'(MAX_SLOTS)
                     : {3'd0, num_slots_q};

  rrst_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .expert_i          (expert_i),
    .load_bytes_i      (load_bytes_i),
    .payload_present_i (payload_present_i),
    .eff_experts_i     (eff_experts),
    .slot_size_i       (slot_size_q),
    .push_o            (push),
    .push_ready_i      (push_ready),
    .req_o             (push_req)
  );

  rrst_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_req),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_req)
  );

  rrst_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (pop_valid),
    .req_i       (pop_req),
    .req_pop_o   (pop),
    .eff_slots_i (eff_slots),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign ok_o         = result.ok;
  assign status_o     = result.status;
  assign slot_o       = result.slot;
  assign slot_state_o = result.slot_state;
  assign ref_count_o  = result.ref_count;
  assign generation_o = result.generation;

endmodule
